/* src/cfir_pkg.sv */
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared types and constants for the centred complex FIR: field widths,
// stream packing, the item opcode and the saturation limits.
// ----------------------------------------------------------------------------
package cfir_pkg;

    // Default sizes
    localparam int MAX_TAPS_DEF  = 32;
    localparam int MAX_BLOCK_DEF = 4096;

    // Field widths
    localparam int SMP_W  = 16;
    localparam int TIDX_W = 5;
    localparam int TCNT_W = 6;
    localparam int OUT_W  = 37;
    localparam int POS_W  = 12;

    // Stream packing
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 88;
    localparam int M_PAD_W  = M_DATA_W - 2 * OUT_W - POS_W;

    // Datapath widths: one complex product part, then a group of eight
    localparam int PROD_W = 2 * SMP_W + 1;
    localparam int GRP_N  = 8;
    localparam int GRP_W  = PROD_W + $clog2(GRP_N);

    // Saturation limits of the 37-bit result
    localparam logic signed [63:0] SAT_HI = 64'sd68719476735;
    localparam logic signed [63:0] SAT_LO = -64'sd68719476736;

    // Item kind, carried on tuser
    typedef enum logic {
        OPC_LOAD   = 1'b0,
        OPC_SAMPLE = 1'b1
    } t_opcode;

    // Complex Q1.15 value
    typedef struct packed {
        logic signed [SMP_W-1:0] im;
        logic signed [SMP_W-1:0] re;
    } t_cplx;

    // Side information travelling with one result
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             last;
    } t_side;

endpackage

/* src/cfir_dp.sv */
// ----------------------------------------------------------------------------
// cfir_dp
// Multiply-accumulate pipeline: aligns the delay line against the taps,
// forms all complex products, sums them in groups of eight, then adds the
// groups and saturates into the output register. Three stages, each with
// its own valid bit, so bubbles close up under back-pressure.
// ----------------------------------------------------------------------------
module cfir_dp
    import cfir_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request in
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_cplx                   i_dl  [MAX_TAPS],
    input  t_cplx                   i_tap [MAX_TAPS],
    input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] i_end,
    input  t_side                   i_side,
    // result out
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_re,
    output logic signed [OUT_W-1:0] o_im,
    output t_side                   o_side
);

    localparam int TW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NG    = (MAX_TAPS + GRP_N - 1) / GRP_N;
    localparam int NL    = NG * GRP_N;
    localparam int FIN_W = GRP_W + ((NG > 1) ? $clog2(NG) : 0);
    localparam int CMP_W = (FIN_W > OUT_W) ? FIN_W : OUT_W;
    localparam logic signed [CMP_W-1:0] LIM_HI = CMP_W'(SAT_HI);
    localparam logic signed [CMP_W-1:0] LIM_LO = CMP_W'(SAT_LO);

    logic                    p_load, g_load, o_load;
    logic [TW-1:0]           sh;
    t_cplx                   lvl [0:TW][0:MAX_TAPS-1];
    logic signed [PROD_W-1:0] n_pr_re [NL];
    logic signed [PROD_W-1:0] n_pr_im [NL];
    logic signed [GRP_W-1:0]  n_g_re [NG];
    logic signed [GRP_W-1:0]  n_g_im [NG];
    logic signed [OUT_W-1:0]  n_o_re, n_o_im;

    logic                     r_p_v, r_g_v, r_o_v;
    logic signed [PROD_W-1:0] r_pr_re [NL];
    logic signed [PROD_W-1:0] r_pr_im [NL];
    t_side                    r_p_side, r_g_side, r_o_side;
    logic signed [GRP_W-1:0]  r_g_re [NG];
    logic signed [GRP_W-1:0]  r_g_im [NG];
    logic signed [OUT_W-1:0]  r_o_re, r_o_im;

    // Clamp a full sum into the 37-bit result range
    function automatic logic signed [OUT_W-1:0] sat(input logic signed [FIN_W-1:0] v);
        logic signed [CMP_W-1:0] x;
        x = CMP_W'(v);
        if (x > LIM_HI) begin
            return OUT_W'(LIM_HI);
        end else if (x < LIM_LO) begin
            return OUT_W'(LIM_LO);
        end
        return OUT_W'(x);
    endfunction

    // Stage advance, from the output back to the input
    assign o_load  = !r_o_v || i_ready;
    assign g_load  = !r_g_v || o_load;
    assign p_load  = !r_p_v || g_load;
    assign o_ready = p_load;

    // Align: lane k sees delay entry (end - k); lanes beyond end see zero
    always_comb begin
        sh = TW'(MAX_TAPS - 1) - i_end;
        for (int k = 0; k < MAX_TAPS; k++) begin
            lvl[0][k] = i_dl[MAX_TAPS - 1 - k];
        end
        for (int l = 0; l < TW; l++) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                if (sh[l]) begin
                    if (k + (1 << l) < MAX_TAPS) begin
                        lvl[l + 1][k] = lvl[l][k + (1 << l)];
                    end else begin
                        lvl[l + 1][k] = '0;
                    end
                end else begin
                    lvl[l + 1][k] = lvl[l][k];
                end
            end
        end
    end

    // Complex products; lanes past the window end are forced to zero
    always_comb begin
        logic signed [2*SMP_W-1:0] rr, ii, ri, ir;
        for (int k = 0; k < NL; k++) begin
            n_pr_re[k] = '0;
            n_pr_im[k] = '0;
        end
        for (int k = 0; k < MAX_TAPS; k++) begin
            rr = i_tap[k].re * lvl[TW][k].re;
            ii = i_tap[k].im * lvl[TW][k].im;
            ri = i_tap[k].re * lvl[TW][k].im;
            ir = i_tap[k].im * lvl[TW][k].re;
            if (k <= int'(i_end)) begin
                n_pr_re[k] = PROD_W'(rr) - PROD_W'(ii);
                n_pr_im[k] = PROD_W'(ri) + PROD_W'(ir);
            end
        end
    end

    // Group sums of eight products
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_g_re[g] = '0;
            n_g_im[g] = '0;
            for (int j = 0; j < GRP_N; j++) begin
                n_g_re[g] = n_g_re[g] + GRP_W'(r_pr_re[g * GRP_N + j]);
                n_g_im[g] = n_g_im[g] + GRP_W'(r_pr_im[g * GRP_N + j]);
            end
        end
    end

    // Final sum and saturation
    always_comb begin
        logic signed [FIN_W-1:0] acc_re, acc_im;
        acc_re = '0;
        acc_im = '0;
        for (int g = 0; g < NG; g++) begin
            acc_re = acc_re + FIN_W'(r_g_re[g]);
            acc_im = acc_im + FIN_W'(r_g_im[g]);
        end
        n_o_re = sat(acc_re);
        n_o_im = sat(acc_im);
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_g_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (p_load) begin
                r_p_v <= i_valid;
            end
            if (g_load) begin
                r_g_v <= r_p_v;
            end
            if (o_load) begin
                r_o_v <= r_g_v;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (p_load && i_valid) begin
            r_pr_re  <= n_pr_re;
            r_pr_im  <= n_pr_im;
            r_p_side <= i_side;
        end
        if (g_load && r_p_v) begin
            r_g_re   <= n_g_re;
            r_g_im   <= n_g_im;
            r_g_side <= r_p_side;
        end
        if (o_load && r_g_v) begin
            r_o_re   <= n_o_re;
            r_o_im   <= n_o_im;
            r_o_side <= r_g_side;
        end
    end

    assign o_valid = r_o_v;
    assign o_re    = r_o_re;
    assign o_im    = r_o_im;
    assign o_side  = r_o_side;

endmodule

/* src/complex_centered_fir.sv */
// ----------------------------------------------------------------------------
// complex_centered_fir
// Centred, same-length complex FIR over blocks of Q1.15 samples with
// Q1.15 taps (not reversed). Output n is the sum of h[k] * x[n + k - M/2];
// samples outside the block count as zero. Sums saturate to 37 bits.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+---------------------------------------
//  s (in)   | in  | tvalid / tready    | tdata: tap index, tap, sample;
//           |     |                    | tuser: opcode; tlast: block end
//  m (out)  | out | tvalid / tready    | tdata: re, im, position; tlast: last
//  cfg      | in  | valid / ready      | data: tap count M
//
//  One item is taken per clock while the issue stage is free and m is not
//  stalled. A sample that ends a block releases up to D + 1 = M - M/2
//  results from the issue stage, one per clock when m does not stall, and
//  holds off further requests until the last of them is issued.
//  Back-pressure on m stalls the three-stage MAC pipeline stage by stage and
//  reaches s only once the pipeline is full. Reset is synchronous, clears the
//  delay line and count and sets the tap count to one; taps are not cleared.
// ----------------------------------------------------------------------------
module complex_centered_fir
    import cfir_pkg::*;
#(
    parameter int MAX_TAPS  = MAX_TAPS_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // tap_index, tap_re, tap_im, sample_re, sample_im
    input  logic                i_s_tuser,  // opcode
    input  logic                i_s_tlast,  // block_end
    // result channel
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // out_re, out_im, out_position
    output logic                o_m_tlast,  // out_last
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [TCNT_W-1:0]   i_cfg_data  // tap_count
);

    localparam int TW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int MW   = $clog2(MAX_TAPS + 1);
    localparam int MC_W = (MW > TCNT_W) ? MW : TCNT_W;
    localparam int CW   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int XW   = ((CW > MW) ? CW : MW) + 1;

    // Registers
    logic [TCNT_W-1:0] r_tc;
    t_cplx             r_tap [MAX_TAPS];
    t_cplx             r_dl  [MAX_TAPS];
    logic [CW-1:0]     r_cnt;
    logic              r_iss_v;
    logic              r_iss_fl;
    logic [TW-1:0]     r_iss_t;
    logic [TW-1:0]     r_iss_end;
    logic [CW-1:0]     r_iss_m;

    // Next values
    t_cplx             n_dl [MAX_TAPS];
    logic [CW-1:0]     n_cnt;
    logic              n_iss_v;
    logic              n_iss_fl;
    logic [TW-1:0]     n_iss_t;
    logic [TW-1:0]     n_iss_end;
    logic [CW-1:0]     n_iss_m;

    // Combinational
    t_opcode           s_opc;
    logic [TIDX_W-1:0] s_tidx;
    t_cplx             s_tap, s_smp;
    logic              s_acc, smp_acc, ld_acc, blk_last;
    logic [MC_W-1:0]   tc_w, m_w;
    logic [MW-1:0]     m_eff, d_eff;
    logic [XW-1:0]     n_x, d_x;
    logic              ge_d;
    logic              dp_ready, iss_fire, iss_done, flush_clr;
    logic [TW-1:0]     win_end;
    t_side             iss_side, out_side;
    logic signed [OUT_W-1:0] out_re, out_im;

    // Unpack the request
    always_comb begin
        s_opc     = t_opcode'(i_s_tuser);
        s_tidx    = i_s_tdata[TIDX_W-1:0];
        s_tap.re  = i_s_tdata[TIDX_W +: SMP_W];
        s_tap.im  = i_s_tdata[TIDX_W + SMP_W +: SMP_W];
        s_smp.re  = i_s_tdata[TIDX_W + 2*SMP_W +: SMP_W];
        s_smp.im  = i_s_tdata[TIDX_W + 3*SMP_W +: SMP_W];
    end

    // Taps in use and look-ahead depth
    always_comb begin
        tc_w = MC_W'(r_tc);
        if (tc_w == '0) begin
            m_w = MC_W'(1);
        end else if (tc_w > MC_W'(MAX_TAPS)) begin
            m_w = MC_W'(MAX_TAPS);
        end else begin
            m_w = tc_w;
        end
        m_eff = MW'(m_w);
        d_eff = m_eff - MW'(1) - (m_eff >> 1);
    end

    // Handshakes
    assign iss_done   = (r_iss_t == r_iss_end);
    assign iss_fire   = r_iss_v && dp_ready;
    assign flush_clr  = iss_fire && iss_done && r_iss_fl;
    assign o_s_tready = i_rst_n && (!r_iss_v || (iss_fire && iss_done));
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign smp_acc    = s_acc && (s_opc == OPC_SAMPLE);
    assign ld_acc     = s_acc && (s_opc == OPC_LOAD);
    assign blk_last   = i_s_tlast || (r_cnt >= CW'(MAX_BLOCK - 1));
    assign o_cfg_ready = 1'b1;

    assign n_x  = XW'(r_cnt);
    assign d_x  = XW'(d_eff);
    assign ge_d = (n_x >= d_x);

    // Issue sequencer: one result per step, several on a block end
    always_comb begin
        n_iss_v   = r_iss_v;
        n_iss_fl  = r_iss_fl;
        n_iss_t   = r_iss_t;
        n_iss_end = r_iss_end;
        n_iss_m   = r_iss_m;
        if (iss_fire) begin
            if (iss_done) begin
                n_iss_v = 1'b0;
            end else begin
                n_iss_t = r_iss_t + TW'(1);
                n_iss_m = r_iss_m + CW'(1);
            end
        end
        if (smp_acc) begin
            if (blk_last) begin
                n_iss_v   = 1'b1;
                n_iss_fl  = 1'b1;
                n_iss_end = TW'(d_eff);
                if (ge_d) begin
                    n_iss_t = '0;
                    n_iss_m = CW'(n_x - d_x);
                end else begin
                    n_iss_t = TW'(d_x - n_x);
                    n_iss_m = '0;
                end
            end else if (ge_d) begin
                n_iss_v   = 1'b1;
                n_iss_fl  = 1'b0;
                n_iss_t   = '0;
                n_iss_end = '0;
                n_iss_m   = CW'(n_x - d_x);
            end
        end
    end

    // Delay line: drop everything after a flush, shift in the new sample
    always_comb begin
        for (int k = 0; k < MAX_TAPS; k++) begin
            n_dl[k] = flush_clr ? '0 : r_dl[k];
        end
        if (smp_acc) begin
            for (int k = MAX_TAPS - 1; k > 0; k--) begin
                n_dl[k] = n_dl[k - 1];
            end
            n_dl[0] = s_smp;
        end
    end

    // Sample count within the block
    always_comb begin
        n_cnt = r_cnt;
        if (smp_acc) begin
            n_cnt = blk_last ? '0 : r_cnt + CW'(1);
        end
    end

    // Window end for the current step and side information
    assign win_end       = TW'(m_eff - MW'(1) - MW'(r_iss_t));
    assign iss_side.pos  = POS_W'(r_iss_m);
    assign iss_side.last = r_iss_fl && iss_done;

    // Control and delay line registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc      <= TCNT_W'(1);
            r_cnt     <= '0;
            r_iss_v   <= 1'b0;
            r_iss_fl  <= 1'b0;
            r_iss_t   <= '0;
            r_iss_end <= '0;
            r_iss_m   <= '0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_dl[k] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tc <= i_cfg_data;
            end
            r_cnt     <= n_cnt;
            r_iss_v   <= n_iss_v;
            r_iss_fl  <= n_iss_fl;
            r_iss_t   <= n_iss_t;
            r_iss_end <= n_iss_end;
            r_iss_m   <= n_iss_m;
            r_dl      <= n_dl;
        end
    end

    // Tap store; loads beyond the store are ignored
    always_ff @(posedge i_clk) begin
        if (ld_acc && (int'(s_tidx) < MAX_TAPS)) begin
            r_tap[TW'(s_tidx)] <= s_tap;
        end
    end

    // Multiply-accumulate pipeline
    cfir_dp #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_iss_v),
        .o_ready (dp_ready),
        .i_dl    (r_dl),
        .i_tap   (r_tap),
        .i_end   (win_end),
        .i_side  (iss_side),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_re    (out_re),
        .o_im    (out_im),
        .o_side  (out_side)
    );

    // Pack the result
    assign o_m_tdata = {{M_PAD_W{1'b0}}, out_side.pos, out_im, out_re};
    assign o_m_tlast = out_side.last;

endmodule

/* src/cfir_chk.sv */
// ----------------------------------------------------------------------------
// cfir_chk
// Port-level checks for the centred complex FIR: result stability under
// stall, quiet output after reset, and contiguous output positions within
// a block while the tap count is left alone.
// ----------------------------------------------------------------------------
module cfir_chk
    import cfir_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [S_DATA_W-1:0] i_s_tdata,  // tap_index, tap_re, tap_im, sample_re, sample_im
    input logic                i_s_tuser,  // opcode
    input logic                i_s_tlast,  // block_end
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,  // out_re, out_im, out_position
    input logic                o_m_tlast,  // out_last
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [TCNT_W-1:0]   i_cfg_data  // tap_count
);

    logic             out_acc;
    logic [POS_W-1:0] out_pos;
    logic [POS_W-1:0] r_exp_pos;
    logic             r_dirty;

    assign out_acc = o_m_tvalid && i_m_tready;
    assign out_pos = o_m_tdata[2*OUT_W +: POS_W];

    // Track the expected position; a tap count write spoils the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_pos <= '0;
            r_dirty   <= 1'b0;
        end else begin
            if (out_acc) begin
                r_exp_pos <= o_m_tlast ? '0 : out_pos + POS_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_dirty <= 1'b1;
            end else if (out_acc && o_m_tlast) begin
                r_dirty <= 1'b0;
            end
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // Nothing leaves right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid straight after reset");

    // Positions run on without gaps and restart after the last result
    a_pos_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !r_dirty && !(i_cfg_valid && o_cfg_ready) |-> out_pos == r_exp_pos)
        else $error("output position out of sequence");

endmodule

bind complex_centered_fir cfir_chk u_cfir_chk (.*);
